/* src/pcf_pkg.sv */
package pcf_pkg;

	localparam int unsigned QDEPTH = 24;
	localparam int unsigned MAX_RES = 12;
	localparam int unsigned QCW = $clog2(QDEPTH + 1);
	localparam int unsigned RCW = $clog2(MAX_RES + 1);

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

	localparam logic MODE_HEADER = 1'b0;
	localparam logic MODE_DATA   = 1'b1;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
		logic       chunk_end;
		logic       error;
	} res_t;

	function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
		end
		return c;
	endfunction

	// crc from all ones over four bytes; linear in the bits, so it flattens to an xor network
	function automatic logic [31:0] crc_word(logic [31:0] w);
		logic [31:0] c;
		c = CRC_ONES;
		for (int i = 0; i < 4; i++) begin
			c = crc_byte(c, w[31 - 8 * i -: 8]);
		end
		return c;
	endfunction

endpackage

/* src/png_chunk_framer_crc32.sv */
// PNG chunk framer with CRC-32.
// Input channel (item_valid / item_stall): mode 0 carries chunk_length and
// chunk_type and starts a chunk; mode 1 carries one data_byte.
// Result channel (res_valid / res_stall): one framed byte per transfer with
// last, chunk_end and error flags.
// An accepted item is held in an input register, where its results (up to
// 12) and the new crc/length state are formed, and then they enter a
// 24-entry result queue, whose head drives the outputs. Data bytes stream
// at one item per cycle while the queue has room; a header produces 8
// results (12 for an empty chunk) which drain at one byte per cycle while
// res_stall is low, so output bandwidth sets the item rate for headers.
// The input register moves into the queue whenever the queue holds 12 or
// fewer results; otherwise item_stall is raised. item_stall depends only on
// registers, never on res_stall directly.
// When the receiver stalls, the head result holds and the queue fills, and
// input stalls once it is over half full.
// Reset empties the queue and the input register, closes any chunk and sets
// the running crc to all ones.
module png_chunk_framer_crc32 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        mode,
	input  logic [30:0] chunk_length,
	input  logic [31:0] chunk_type,
	input  logic [7:0]  data_byte,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [7:0]  out_byte,
	output logic        last,
	output logic        chunk_end,
	output logic        error
);

	logic        valid_s1;
	logic        mode_s1;
	logic [30:0] len_s1;
	logic [31:0] type_s1;
	logic [7:0]  data_s1;

	logic [31:0] crc_q;
	logic [30:0] left_q;
	logic        open_q;

	pcf_pkg::res_t queue_q [pcf_pkg::QDEPTH];
	pcf_pkg::res_t queue_d [pcf_pkg::QDEPTH];
	logic [pcf_pkg::QCW-1:0] count_q;
	logic [pcf_pkg::QCW-1:0] count_d;
	logic [pcf_pkg::QCW-1:0] base;
	logic [pcf_pkg::QCW-1:0] off [pcf_pkg::QDEPTH];

	pcf_pkg::res_t res [pcf_pkg::MAX_RES];
	logic [pcf_pkg::RCW-1:0] n_res;
	logic [31:0] crc_d;
	logic [30:0] left_d;
	logic        open_d;
	logic [31:0] hdr_crc;
	logic [31:0] dat_crc;
	logic [31:0] fin_crc;
	logic        go;
	logic        pop;
	logic        take;

	assign go   = valid_s1 && (count_q <= pcf_pkg::QCW'(pcf_pkg::MAX_RES));
	assign item_stall = valid_s1 && !go;
	assign take = item_valid && !item_stall;
	assign res_valid = (count_q != '0);
	assign pop  = res_valid && !res_stall;

	assign out_byte  = queue_q[0].out_byte;
	assign last      = queue_q[0].last;
	assign chunk_end = queue_q[0].chunk_end;
	assign error     = queue_q[0].error;

	assign hdr_crc = pcf_pkg::crc_word(type_s1);
	assign dat_crc = pcf_pkg::crc_byte(crc_q, data_s1);

	// results and next state of the item in the input register
	always_comb begin
		for (int i = 0; i < pcf_pkg::MAX_RES; i++) begin
			res[i] = '0;
		end
		n_res  = '0;
		crc_d  = crc_q;
		left_d = left_q;
		open_d = open_q;
		fin_crc = '0;
		if (mode_s1 == pcf_pkg::MODE_HEADER) begin
			for (int i = 0; i < 4; i++) begin
				res[i].out_byte = 8'({1'b0, len_s1} >> (24 - 8 * i));
				res[i + 4].out_byte = type_s1[31 - 8 * i -: 8];
			end
			if (len_s1 == '0) begin
				fin_crc = hdr_crc ^ pcf_pkg::CRC_ONES;
				for (int i = 0; i < 4; i++) begin
					res[i + 8].out_byte = fin_crc[31 - 8 * i -: 8];
				end
				res[11].last      = 1'b1;
				res[11].chunk_end = 1'b1;
				n_res  = pcf_pkg::RCW'(12);
				crc_d  = pcf_pkg::CRC_ONES;
				left_d = '0;
				open_d = 1'b0;
			end else begin
				res[7].last = 1'b1;
				n_res  = pcf_pkg::RCW'(8);
				crc_d  = hdr_crc;
				left_d = len_s1;
				open_d = 1'b1;
			end
		end else if (!open_q) begin
			res[0].last  = 1'b1;
			res[0].error = 1'b1;
			n_res = pcf_pkg::RCW'(1);
		end else begin
			res[0].out_byte = data_s1;
			if (left_q == 31'd1) begin
				fin_crc = dat_crc ^ pcf_pkg::CRC_ONES;
				for (int i = 0; i < 4; i++) begin
					res[i + 1].out_byte = fin_crc[31 - 8 * i -: 8];
				end
				res[4].last      = 1'b1;
				res[4].chunk_end = 1'b1;
				n_res  = pcf_pkg::RCW'(5);
				crc_d  = pcf_pkg::CRC_ONES;
				left_d = '0;
				open_d = 1'b0;
			end else begin
				res[0].last = 1'b1;
				n_res  = pcf_pkg::RCW'(1);
				crc_d  = dat_crc;
				left_d = left_q - 31'd1;
			end
		end
	end

	// shift queue: head pops, new results append after what remains
	always_comb begin
		base = count_q - pcf_pkg::QCW'(pop);
		for (int j = 0; j < pcf_pkg::QDEPTH; j++) begin
			off[j] = pcf_pkg::QCW'(j) - base;
			if (pop && j < pcf_pkg::QDEPTH - 1) begin
				queue_d[j] = queue_q[(j + 1) % pcf_pkg::QDEPTH];
			end else begin
				queue_d[j] = queue_q[j];
			end
			if (go && pcf_pkg::QCW'(j) >= base && off[j] < pcf_pkg::QCW'(n_res)) begin
				queue_d[j] = res[off[j][pcf_pkg::RCW-1:0]];
			end
		end
		count_d = base + (go ? pcf_pkg::QCW'(n_res) : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			count_q  <= '0;
			crc_q    <= pcf_pkg::CRC_ONES;
			left_q   <= '0;
			open_q   <= 1'b0;
		end else begin
			if (!item_stall) begin
				valid_s1 <= item_valid;
			end
			count_q <= count_d;
			if (go) begin
				crc_q  <= crc_d;
				left_q <= left_d;
				open_q <= open_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			mode_s1 <= mode;
			len_s1  <= chunk_length;
			type_s1 <= chunk_type;
			data_s1 <= data_byte;
		end
		queue_q <= queue_d;
	end

endmodule
